// ===== rtl/core/tlsg_pkg.sv =====
// ============================================================================
// Thick line span generator package
// Shared widths and the command and status bundles between the controller
// and the datapath.
// ============================================================================
package tlsg_pkg;

    localparam int COORD_W  = 16;   // pixel coordinates, wrap modulo 2^COORD_W
    localparam int RADIUS_W = 8;    // brush radius
    localparam int LEN_W    = 9;    // span length, up to twice the radius
    localparam int COLOR_W  = 16;   // pixel color

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // latch a new line from the input request
        logic setup;         // derive the circle limits of the brush
        logic step;          // advance the span walker by one slot
        logic capture_held;  // keep the current span as the pending one
        logic capture_next;  // keep the current span as the one after it
        logic promote;       // move the span after into the pending one
        logic out_span;      // load the output register with the pending span
        logic out_empty;     // load the output register with an empty result
        logic out_last;      // last flag for out_span
    } tlsg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic active;        // a line is still being walked
        logic emit_ok;       // this slot yields a span of non-zero length
    } tlsg_status_t;

endpackage

// ===== rtl/core/tlsg_datapath.sv =====
// ============================================================================
// Thick line span generator datapath
// Line walker, circle span walker, pending span buffers and output register.
// ============================================================================
module tlsg_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  tlsg_pkg::tlsg_cmd_t            cmd,
    output tlsg_pkg::tlsg_status_t         status,
    input  logic [tlsg_pkg::COORD_W-1:0]   start_x,
    input  logic [tlsg_pkg::COORD_W-1:0]   start_y,
    input  logic [tlsg_pkg::COORD_W-1:0]   end_x,
    input  logic [tlsg_pkg::COORD_W-1:0]   end_y,
    input  logic [tlsg_pkg::RADIUS_W-1:0]  thickness,
    input  logic [tlsg_pkg::COLOR_W-1:0]   pen_color,
    output logic                           span_valid,
    output logic [tlsg_pkg::COORD_W-1:0]   span_x,
    output logic [tlsg_pkg::COORD_W-1:0]   span_y,
    output logic [tlsg_pkg::LEN_W-1:0]     span_length,
    output logic [tlsg_pkg::COLOR_W-1:0]   span_color,
    output logic                           last_span
);
    import tlsg_pkg::*;

    localparam int ERR_W   = COORD_W + 2;
    localparam int STAMP_W = COORD_W + 1;
    localparam int SQ_W    = 2 * RADIUS_W + 1;
    localparam int P181_W  = RADIUS_W + 8;
    localparam int P707_W  = RADIUS_W + 10;

    typedef enum logic [1:0] {
        DIR_STILL = 2'd0,
        DIR_UP    = 2'd1,
        DIR_DOWN  = 2'd2
    } dir_t;

    typedef enum logic [2:0] {
        SLOT_CENTER    = 3'd0,
        SLOT_TEST      = 3'd1,
        SLOT_OUTER_LO  = 3'd2,
        SLOT_OUTER_HI  = 3'd3,
        SLOT_INNER_LO  = 3'd4,
        SLOT_INNER_HI  = 3'd5
    } slot_t;

    function automatic logic [COORD_W-1:0] move_axis(input logic [COORD_W-1:0] pos,
                                                     input dir_t dir);
        logic [COORD_W-1:0] res;
        begin
            case (dir)
                DIR_UP:   res = pos + COORD_W'(1);
                DIR_DOWN: res = pos - COORD_W'(1);
                default:  res = pos;
            endcase
            return res;
        end
    endfunction

    // Line and brush state.
    logic                 active_reg, active_next;
    logic [COORD_W-1:0]   pen_col_reg, pen_col_next, pen_row_reg, pen_row_next;
    logic [ERR_W-1:0]     col_err_reg, col_err_next, row_err_reg, row_err_next;
    logic [COORD_W-1:0]   col_delta_reg, col_delta_next, row_delta_reg, row_delta_next;
    dir_t                 col_dir_reg, col_dir_next, row_dir_reg, row_dir_next;
    logic [COORD_W-1:0]   major_reg, major_next;
    logic [STAMP_W-1:0]   stamps_reg, stamps_next;
    logic [RADIUS_W-1:0]  radius_reg, radius_next;
    logic [RADIUS_W-1:0]  row_limit_reg, row_limit_next;
    logic [SQ_W-1:0]      sq_limit_reg, sq_limit_next;
    logic [RADIUS_W-1:0]  circle_row_reg, circle_row_next;
    logic [RADIUS_W-1:0]  half_width_reg, half_width_next;
    logic [2:0]           slot_reg, slot_next;
    logic [COLOR_W-1:0]   color_reg, color_next;
    logic [P181_W-1:0]    p181_reg, p181_next;
    logic [P707_W-1:0]    p707_reg, p707_next;
    logic [2*RADIUS_W-1:0] psq_reg, psq_next;

    // Pending span, the span after it, and the output register.
    logic [COORD_W-1:0]   held_x_reg, held_y_reg, nxt_x_reg, nxt_y_reg;
    logic [LEN_W-1:0]     held_len_reg, nxt_len_reg;
    logic                 out_vld_reg, out_last_reg;
    logic [COORD_W-1:0]   out_x_reg, out_y_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic [COLOR_W-1:0]   out_color_reg;

    // Current slot's span.
    logic                 emit;
    logic [COORD_W-1:0]   cur_x, cur_y;
    logic [LEN_W-1:0]     cur_len;

    // Helper terms.
    logic [COORD_W-1:0]   r_ext, x_ext, i_ext;
    logic [RADIUS_W-1:0]  i_m1, x_dec;
    logic [SQ_W-1:0]      circ_sum;
    logic [ERR_W-1:0]     col_sum, row_sum;
    logic                 col_hit, row_hit, stamp_end;
    logic [STAMP_W-1:0]   stamps_inc;
    logic                 reject;
    logic [RADIUS_W-1:0]  q0;
    logic [P707_W-1:0]    q_scaled;
    logic                 q_over;

    always_comb
    begin
        r_ext      = COORD_W'(radius_reg);
        x_ext      = COORD_W'(half_width_reg);
        i_ext      = COORD_W'(circle_row_reg);
        i_m1       = circle_row_reg - RADIUS_W'(1);
        x_dec      = (half_width_reg != '0) ? half_width_reg - RADIUS_W'(1) : half_width_reg;
        circ_sum   = SQ_W'(circle_row_reg) * SQ_W'(circle_row_reg)
                   + SQ_W'(half_width_reg) * SQ_W'(half_width_reg);
        col_sum    = col_err_reg + ERR_W'(col_delta_reg);
        row_sum    = row_err_reg + ERR_W'(row_delta_reg);
        col_hit    = col_sum > ERR_W'(major_reg);
        row_hit    = row_sum > ERR_W'(major_reg);
        stamps_inc = stamps_reg + STAMP_W'(1);
        stamp_end  = stamps_inc >= (STAMP_W'(major_reg) + STAMP_W'(2));
        reject     = (thickness == '0) || (start_x < COORD_W'(thickness))
                   || (end_x < COORD_W'(thickness)) || (start_y < COORD_W'(thickness))
                   || (end_y < COORD_W'(thickness));
        // Row limit is r * 707 / 1000 + 1, from an estimate r * 181 / 256 that is
        // never low, corrected by one where it overshoots.
        q0         = p181_reg[P181_W-1:8];
        q_scaled   = P707_W'(q0) * P707_W'(1000);
        q_over     = q_scaled > p707_reg;
    end

    // Span of the current slot.
    always_comb
    begin
        emit    = 1'b0;
        cur_x   = pen_col_reg - x_ext;
        cur_y   = pen_row_reg + i_ext;
        cur_len = {half_width_reg, 1'b0};
        case (slot_reg)
            SLOT_CENTER:
            begin
                emit    = 1'b1;
                cur_x   = pen_col_reg - r_ext;
                cur_y   = pen_row_reg;
                cur_len = {radius_reg, 1'b0};
            end
            SLOT_OUTER_LO, SLOT_OUTER_HI:
            begin
                emit    = 1'b1;
                cur_x   = pen_col_reg + COORD_W'(1) - i_ext;
                cur_y   = (slot_reg == SLOT_OUTER_LO) ? pen_row_reg + x_ext
                                                      : pen_row_reg - x_ext;
                cur_len = {i_m1, 1'b0};
            end
            SLOT_INNER_LO:
            begin
                emit = 1'b1;
            end
            SLOT_INNER_HI:
            begin
                emit  = 1'b1;
                cur_y = pen_row_reg - i_ext;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign status.active  = active_reg;
    assign status.emit_ok = active_reg && emit && (cur_len != '0);

    // Next state of the walker.
    always_comb
    begin
        active_next     = active_reg;
        pen_col_next    = pen_col_reg;
        pen_row_next    = pen_row_reg;
        col_err_next    = col_err_reg;
        row_err_next    = row_err_reg;
        col_delta_next  = col_delta_reg;
        row_delta_next  = row_delta_reg;
        col_dir_next    = col_dir_reg;
        row_dir_next    = row_dir_reg;
        major_next      = major_reg;
        stamps_next     = stamps_reg;
        radius_next     = radius_reg;
        row_limit_next  = row_limit_reg;
        sq_limit_next   = sq_limit_reg;
        circle_row_next = circle_row_reg;
        half_width_next = half_width_reg;
        slot_next       = slot_reg;
        color_next      = color_reg;
        p181_next       = p181_reg;
        p707_next       = p707_reg;
        psq_next        = psq_reg;

        if (cmd.load)
        begin
            active_next     = !reject;
            pen_col_next    = start_x;
            pen_row_next    = start_y;
            col_err_next    = '0;
            row_err_next    = '0;
            col_dir_next    = DIR_STILL;
            row_dir_next    = DIR_STILL;
            col_delta_next  = '0;
            row_delta_next  = '0;
            if (end_x > start_x)
            begin
                col_dir_next   = DIR_UP;
                col_delta_next = end_x - start_x;
            end
            else if (end_x < start_x)
            begin
                col_dir_next   = DIR_DOWN;
                col_delta_next = start_x - end_x;
            end
            if (end_y > start_y)
            begin
                row_dir_next   = DIR_UP;
                row_delta_next = end_y - start_y;
            end
            else if (end_y < start_y)
            begin
                row_dir_next   = DIR_DOWN;
                row_delta_next = start_y - end_y;
            end
            major_next      = (col_delta_next > row_delta_next) ? col_delta_next
                                                                : row_delta_next;
            stamps_next     = '0;
            radius_next     = thickness;
            circle_row_next = '0;
            half_width_next = thickness;
            slot_next       = SLOT_CENTER;
            color_next      = pen_color;
            p181_next       = P181_W'(thickness) * P181_W'(181);
            p707_next       = P707_W'(thickness) * P707_W'(707);
            psq_next        = (2 * RADIUS_W)'(thickness) * (2 * RADIUS_W)'(thickness);
        end
        else if (cmd.setup)
        begin
            row_limit_next = q0 - RADIUS_W'(q_over) + RADIUS_W'(1);
            sq_limit_next  = SQ_W'(psq_reg) + SQ_W'(radius_reg >> 1);
        end
        else if (cmd.step && active_reg)
        begin
            case (slot_reg)
                SLOT_CENTER:
                begin
                    circle_row_next = RADIUS_W'(1);
                    slot_next       = SLOT_TEST;
                end
                SLOT_TEST:
                begin
                    if (circ_sum > sq_limit_reg && half_width_reg > row_limit_reg)
                    begin
                        slot_next = SLOT_OUTER_LO;
                    end
                    else
                    begin
                        if (circ_sum > sq_limit_reg)
                        begin
                            half_width_next = x_dec;
                        end
                        slot_next = SLOT_INNER_LO;
                    end
                end
                SLOT_OUTER_LO:
                begin
                    slot_next = SLOT_OUTER_HI;
                end
                SLOT_OUTER_HI:
                begin
                    half_width_next = x_dec;
                    slot_next       = SLOT_INNER_LO;
                end
                SLOT_INNER_LO:
                begin
                    slot_next = SLOT_INNER_HI;
                end
                SLOT_INNER_HI:
                begin
                    if (circle_row_reg >= row_limit_reg)
                    begin
                        // Circle finished: move the pen one stamp along the line.
                        col_err_next = col_hit ? col_sum - ERR_W'(major_reg) : col_sum;
                        row_err_next = row_hit ? row_sum - ERR_W'(major_reg) : row_sum;
                        if (col_hit)
                        begin
                            pen_col_next = move_axis(pen_col_reg, col_dir_reg);
                        end
                        if (row_hit)
                        begin
                            pen_row_next = move_axis(pen_row_reg, row_dir_reg);
                        end
                        stamps_next = stamps_inc;
                        if (stamp_end)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            slot_next       = SLOT_CENTER;
                            circle_row_next = '0;
                            half_width_next = radius_reg;
                        end
                    end
                    else
                    begin
                        circle_row_next = circle_row_reg + RADIUS_W'(1);
                        slot_next       = SLOT_TEST;
                    end
                end
                default:
                begin
                    slot_next = SLOT_CENTER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            out_last_reg <= 1'b1;
        end
        else
        begin
            active_reg <= active_next;
            if (cmd.out_span)
            begin
                out_vld_reg  <= 1'b1;
                out_last_reg <= cmd.out_last;
            end
            else if (cmd.out_empty)
            begin
                out_vld_reg  <= 1'b0;
                out_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pen_col_reg    <= pen_col_next;
        pen_row_reg    <= pen_row_next;
        col_err_reg    <= col_err_next;
        row_err_reg    <= row_err_next;
        col_delta_reg  <= col_delta_next;
        row_delta_reg  <= row_delta_next;
        col_dir_reg    <= col_dir_next;
        row_dir_reg    <= row_dir_next;
        major_reg      <= major_next;
        stamps_reg     <= stamps_next;
        radius_reg     <= radius_next;
        row_limit_reg  <= row_limit_next;
        sq_limit_reg   <= sq_limit_next;
        circle_row_reg <= circle_row_next;
        half_width_reg <= half_width_next;
        slot_reg       <= slot_next;
        color_reg      <= color_next;
        p181_reg       <= p181_next;
        p707_reg       <= p707_next;
        psq_reg        <= psq_next;

        if (cmd.capture_held)
        begin
            held_x_reg   <= cur_x;
            held_y_reg   <= cur_y;
            held_len_reg <= cur_len;
        end
        else if (cmd.promote)
        begin
            held_x_reg   <= nxt_x_reg;
            held_y_reg   <= nxt_y_reg;
            held_len_reg <= nxt_len_reg;
        end

        if (cmd.capture_next)
        begin
            nxt_x_reg   <= cur_x;
            nxt_y_reg   <= cur_y;
            nxt_len_reg <= cur_len;
        end

        if (cmd.out_span)
        begin
            out_x_reg     <= held_x_reg;
            out_y_reg     <= held_y_reg;
            out_len_reg   <= held_len_reg;
            out_color_reg <= color_reg;
        end
        else if (cmd.out_empty)
        begin
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_len_reg   <= '0;
            out_color_reg <= '0;
        end
    end

    assign span_valid  = out_vld_reg;
    assign span_x      = out_x_reg;
    assign span_y      = out_y_reg;
    assign span_length = out_len_reg;
    assign span_color  = out_color_reg;
    assign last_span   = out_last_reg;

endmodule

// ===== rtl/core/tlsg_ctrl.sv =====
// ============================================================================
// Thick line span generator controller
// Sequences line loads, span searches and the output handshake.
// ============================================================================
module tlsg_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    in_op,
    output logic                    out_valid,
    input  logic                    out_ready,
    output tlsg_pkg::tlsg_cmd_t     cmd,
    input  tlsg_pkg::tlsg_status_t  status
);
    import tlsg_pkg::*;

    typedef enum logic [2:0] {
        ST_READY,
        ST_SETUP,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    localparam logic OP_LOAD = 1'b0;

    state_t state_reg, state_next;
    logic   have_reg, have_next;    // a pending span is buffered
    logic   found_reg, found_next;  // a span after the pending one exists
    logic   fill_reg, fill_next;    // search fills the pending span after a load
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_READY);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        have_next      = have_reg;
        found_next     = found_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;

        unique case (state_reg)
            ST_READY:
            begin
                if (in_valid)
                begin
                    if (in_op == OP_LOAD)
                    begin
                        cmd.load   = 1'b1;
                        have_next  = 1'b0;
                        state_next = ST_SETUP;
                    end
                    else if (have_reg)
                    begin
                        fill_next  = 1'b0;
                        state_next = ST_SEARCH;
                    end
                    else
                    begin
                        found_next = 1'b0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                fill_next  = 1'b1;
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cmd.step = 1'b1;
                if (status.emit_ok || !status.active)
                begin
                    if (fill_reg)
                    begin
                        cmd.capture_held = status.emit_ok;
                        have_next        = status.emit_ok;
                        state_next       = ST_READY;
                    end
                    else
                    begin
                        cmd.capture_next = status.emit_ok;
                        found_next       = status.emit_ok;
                        state_next       = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (have_reg)
                    begin
                        cmd.out_span = 1'b1;
                        cmd.out_last = !found_reg;
                        cmd.promote  = found_reg;
                    end
                    else
                    begin
                        cmd.out_empty = 1'b1;
                    end
                    have_next      = have_reg && found_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            have_reg      <= 1'b0;
            found_reg     <= 1'b0;
            fill_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_reg      <= have_next;
            found_reg     <= found_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/thick_line_span_generator_top.sv =====
// ============================================================================
// Thick line span generator
// Turns a thick line into horizontal spans of circular brush stamps.
// ============================================================================
// The input channel carries two kinds of request. A load request (op = 0)
// hands over a line from (start_x, start_y) to (end_x, end_y), a brush radius
// (thickness) and a color; it produces no result. A line whose radius is zero
// or whose endpoint coordinates lie below the radius gives no spans.
// A pull request (op = 1) produces exactly one result: the next non-empty
// span with last_span high on the final one, or span_valid low and last_span
// high once nothing remains. A load abandons any spans still pending.
// A load passes through the accept, the setup state and one search step,
// which always finds the center span of the first stamp or sees a rejected
// line. A pull passes through the accept, one step of the span walker per
// slot until the following span is found (one or two steps, more where
// spans of zero width are skipped, none where no span is pending) and the
// output register write. The walker steps one slot of the circle sequence per
// cycle, and the block finds one span ahead so that the last flag is known.
// Requests are taken one at a time; a new request is accepted while an
// earlier result still waits in the output register, but a pull only writes
// its result once that register is free, so a stalled receiver holds the
// block in its final cycle. Reset returns the block to idle with no line.
// ============================================================================
module thick_line_span_generator_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           op,
    input  logic [tlsg_pkg::COORD_W-1:0]   start_x,
    input  logic [tlsg_pkg::COORD_W-1:0]   start_y,
    input  logic [tlsg_pkg::COORD_W-1:0]   end_x,
    input  logic [tlsg_pkg::COORD_W-1:0]   end_y,
    input  logic [tlsg_pkg::RADIUS_W-1:0]  thickness,
    input  logic [tlsg_pkg::COLOR_W-1:0]   pen_color,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           span_valid,
    output logic [tlsg_pkg::COORD_W-1:0]   span_x,
    output logic [tlsg_pkg::COORD_W-1:0]   span_y,
    output logic [tlsg_pkg::LEN_W-1:0]     span_length,
    output logic [tlsg_pkg::COLOR_W-1:0]   span_color,
    output logic                           last_span
);
    import tlsg_pkg::*;

    // Commands flow from the controller; the datapath reports whether a line
    // is active and whether the slot it is on yields a span.
    tlsg_cmd_t    cmd;
    tlsg_status_t status;

    tlsg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath holds the line walker, the circle span walker, the pending
    // span buffers and the output register.
    tlsg_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .thickness   (thickness),
        .pen_color   (pen_color),
        .span_valid  (span_valid),
        .span_x      (span_x),
        .span_y      (span_y),
        .span_length (span_length),
        .span_color  (span_color),
        .last_span   (last_span)
    );

endmodule
